/* hw/rtl/cache_line_write_buffer_unit_assert.svh */
// ----------------------------------------------------------------------------
// Cache line write buffer - assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef CACHE_LINE_WRITE_BUFFER_UNIT_ASSERT_SVH
`define CACHE_LINE_WRITE_BUFFER_UNIT_ASSERT_SVH

// Property that must hold at every rising clock edge.
`define CWB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the trigger.
`define CWB_ASSERT_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/cwb_pkg.sv */
// ----------------------------------------------------------------------------
// Cache line write buffer - package
// Sizes, codes, shared types and address helpers.
// ----------------------------------------------------------------------------
package cwb_pkg;

  localparam int ENTRIES    = 8;
  localparam int LINE_WORDS = 16;

  localparam int PTR_W     = $clog2(ENTRIES);
  localparam int OCC_W     = $clog2(ENTRIES + 1);
  localparam int BEAT_W    = $clog2(LINE_WORDS);
  localparam int MEM_DEPTH = ENTRIES * LINE_WORDS;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  localparam int WORD_W    = 32;
  localparam int ADDR_W    = 32;
  localparam int OFFS_W    = 4;
  localparam int WM_W      = 4;
  localparam int HIT_IDX_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CMP_W     = (OCC_W > WM_W) ? OCC_W : WM_W;

  typedef enum logic [1:0] {
    MODE_DRAIN  = 2'd0,
    MODE_PUSH   = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_IDLE   = 2'd3
  } cwb_mode_e;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_WM = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_WM  = CFG_IDX_W'(1);

  localparam logic [WM_W-1:0] HIGH_WM_RST = WM_W'(6);
  localparam logic [WM_W-1:0] LOW_WM_RST  = WM_W'(2);

  typedef struct packed {
    logic             hit;
    logic [PTR_W-1:0] idx;
  } cwb_match_t;

  // Flat word store address of (entry, word)
  function automatic logic [MEM_AW-1:0] word_addr(logic [PTR_W-1:0]  entry,
                                                  logic [BEAT_W-1:0] word);
    word_addr = MEM_AW'(entry) * MEM_AW'(LINE_WORDS) + MEM_AW'(word);
  endfunction

  function automatic logic offs_in_line(logic [OFFS_W-1:0] offs);
    offs_in_line = (32'(offs) < 32'(LINE_WORDS));
  endfunction

endpackage

/* hw/rtl/cache_line_write_buffer_unit.sv */
// Path: an accepted beat passes the input register (s1), then the output register (s2).
// Throughput: one beat per cycle unless out_ready_i stalls s2; the input register,
// the state update and the word store read all run once per cycle: nothing iterates.
// Reset: valid bits, pointers, occupancy, beat state and priority flag clear;
// watermarks load 6 and 2; line addresses and the word store stay undefined
// until written, so the block is ready right after reset.
// ----------------------------------------------------------------------------
// Cache line write buffer unit
// Circular buffer of dirty lines: push word by word, drain head line as a
// write burst to the memory arbiter, watermark priority flag, word lookup.
// ----------------------------------------------------------------------------
module cache_line_write_buffer_unit import cwb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  // config write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [WM_W-1:0]      cfg_data_i,

  // input beats
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           mode_i,
  input  logic                 arb_done_i,
  input  logic                 arb_last_i,
  input  logic [ADDR_W-1:0]    line_addr_i,
  input  logic [OFFS_W-1:0]    word_offset_i,
  input  logic [WORD_W-1:0]    push_word_i,
  input  logic                 push_last_i,

  // result beats
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 ready_res_o,
  output logic                 high_priority_o,
  output logic                 req_valid_o,
  output logic [ADDR_W-1:0]    req_addr_o,
  output logic [WORD_W-1:0]    req_data_o,
  output logic                 req_beat_o,
  output logic                 req_final_o,
  output logic                 push_dropped_o,
  output logic                 hit_o,
  output logic [HIT_IDX_W-1:0] hit_index_o,
  output logic [WORD_W-1:0]    hit_word_o
);

  // Result fields held in the output stage; the two words come straight
  // from the word store's read registers and are masked on the way out.
  typedef struct packed {
    logic                 ready_res;
    logic                 high_priority;
    logic                 req_valid;
    logic [ADDR_W-1:0]    req_addr;
    logic                 req_beat;
    logic                 req_final;
    logic                 push_dropped;
    logic                 hit;
    logic [HIT_IDX_W-1:0] hit_index;
    logic                 hit_word_ok;
  } cwb_res_t;

  // --------------------------------------------------------------------------
  // Config registers (to be written only while idle; the block does not enforce it)
  // --------------------------------------------------------------------------
  logic [WM_W-1:0] high_wm_q;
  logic [WM_W-1:0] low_wm_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_wm_q <= HIGH_WM_RST;
      low_wm_q  <= LOW_WM_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_HIGH_WM: high_wm_q <= cfg_data_i;
        CFG_LOW_WM:  low_wm_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: input register (s1) feeds the output register (s2).
  // The buffer state updates when a beat leaves s1.
  // --------------------------------------------------------------------------
  logic s1_valid_q;
  logic s2_valid_q;
  logic s2_ready;
  logic s1_fire;
  logic in_fire;

  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && s2_ready;
  assign in_ready_o = !s1_valid_q || s2_ready;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  cwb_mode_e         s1_mode_q;
  logic              s1_arb_done_q;
  logic              s1_arb_last_q;
  logic [ADDR_W-1:0] s1_line_addr_q;
  logic [OFFS_W-1:0] s1_offs_q;
  logic [WORD_W-1:0] s1_push_word_q;
  logic              s1_push_last_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_mode_q      <= cwb_mode_e'(mode_i);
      s1_arb_done_q  <= arb_done_i;
      s1_arb_last_q  <= arb_last_i;
      s1_line_addr_q <= line_addr_i;
      s1_offs_q      <= word_offset_i;
      s1_push_word_q <= push_word_i;
      s1_push_last_q <= push_last_i;
    end
  end

  // --------------------------------------------------------------------------
  // Buffer state
  // --------------------------------------------------------------------------
  logic [ENTRIES-1:0] entry_valid_q, entry_valid_d;
  logic [ADDR_W-1:0]  entry_addr_q [ENTRIES];
  logic [PTR_W-1:0]   head_ptr_q, head_ptr_d;
  logic [PTR_W-1:0]   tail_ptr_q, tail_ptr_d;
  logic [OCC_W-1:0]   occ_q, occ_d;
  logic [BEAT_W-1:0]  beat_index_q, beat_index_d;
  logic               beat_pending_q, beat_pending_d;
  logic               prio_q, prio_d;

  // Lookup against the state at the start of the beat
  cwb_match_t match;

  cwb_lookup u_lookup (
    .entry_valid_i (entry_valid_q),
    .entry_addr_i  (entry_addr_q),
    .line_addr_i   (s1_line_addr_q),
    .match_o       (match)
  );

  logic done, last, hv, full, push_ok, offs_ok, beat_at_end;

  assign done        = (s1_mode_q == MODE_DRAIN) && s1_arb_done_q;
  assign last        = (s1_mode_q == MODE_DRAIN) && s1_arb_last_q;
  assign hv          = entry_valid_q[head_ptr_q];
  assign full        = (occ_q >= OCC_W'(ENTRIES));
  assign push_ok     = (s1_mode_q == MODE_PUSH) && !full;
  assign offs_ok     = offs_in_line(s1_offs_q);
  assign beat_at_end = (beat_index_q == BEAT_W'(LINE_WORDS - 1));

  // Hysteresis: high test wins when the marks cross
  always_comb begin
    if (CMP_W'(occ_q) >= CMP_W'(high_wm_q)) begin
      prio_d = 1'b1;
    end else if (CMP_W'(occ_q) <= CMP_W'(low_wm_q)) begin
      prio_d = 1'b0;
    end else begin
      prio_d = prio_q;
    end
  end

  // Drain and push updates; drain last and push last never share a beat
  always_comb begin
    entry_valid_d  = entry_valid_q;
    head_ptr_d     = head_ptr_q;
    tail_ptr_d     = tail_ptr_q;
    occ_d          = occ_q;
    beat_index_d   = beat_index_q;
    beat_pending_d = beat_pending_q;

    if (hv) begin
      beat_pending_d = (beat_index_q == '0) ? 1'b1 : !done;
      if (done && !beat_at_end) begin
        beat_index_d = beat_index_q + BEAT_W'(1);
      end
      if (last) begin
        entry_valid_d[head_ptr_q] = 1'b0;
        beat_pending_d            = 1'b0;
        beat_index_d              = '0;
        if (occ_q != '0) begin
          head_ptr_d = (head_ptr_q == PTR_W'(ENTRIES - 1)) ? '0 : head_ptr_q + PTR_W'(1);
          occ_d      = occ_q - OCC_W'(1);
        end
      end
    end

    if (push_ok && s1_push_last_q) begin
      entry_valid_d[tail_ptr_q] = 1'b1;
      tail_ptr_d = (tail_ptr_q == PTR_W'(ENTRIES - 1)) ? '0 : tail_ptr_q + PTR_W'(1);
      occ_d      = occ_q + OCC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q  <= '0;
      head_ptr_q     <= '0;
      tail_ptr_q     <= '0;
      occ_q          <= '0;
      beat_index_q   <= '0;
      beat_pending_q <= 1'b0;
      prio_q         <= 1'b0;
    end else if (s1_fire) begin
      entry_valid_q  <= entry_valid_d;
      head_ptr_q     <= head_ptr_d;
      tail_ptr_q     <= tail_ptr_d;
      occ_q          <= occ_d;
      beat_index_q   <= beat_index_d;
      beat_pending_q <= beat_pending_d;
      prio_q         <= prio_d;
    end
  end

  // Line address is taken on every accepted push word
  always_ff @(posedge clk_i) begin
    if (s1_fire && push_ok) begin
      entry_addr_q[tail_ptr_q] <= s1_line_addr_q;
    end
  end

  // --------------------------------------------------------------------------
  // Word store: port a reads the head burst word, port b the lookup word.
  // Reads return the word as it was before this beat's push write.
  // --------------------------------------------------------------------------
  logic [WORD_W-1:0] head_word;
  logic [WORD_W-1:0] look_word;

  cwb_word_ram #(
    .DEPTH (MEM_DEPTH),
    .WIDTH (WORD_W)
  ) u_word_ram (
    .clk_i     (clk_i),
    .we_i      (s1_fire && push_ok && offs_ok),
    .waddr_i   (word_addr(tail_ptr_q, BEAT_W'(s1_offs_q))),
    .wdata_i   (s1_push_word_q),
    .re_i      (s1_fire),
    .raddr_a_i (word_addr(head_ptr_q, beat_index_q)),
    .raddr_b_i (word_addr(match.idx, BEAT_W'(s1_offs_q))),
    .rdata_a_o (head_word),
    .rdata_b_o (look_word)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  cwb_res_t res_d, res_q;
  logic     look_hit;

  assign look_hit = (s1_mode_q == MODE_LOOKUP) && match.hit;

  always_comb begin
    res_d               = '0;
    res_d.ready_res     = !full;
    res_d.high_priority = prio_d;
    res_d.req_valid     = hv;
    res_d.req_addr      = hv ? entry_addr_q[head_ptr_q] : '0;
    res_d.req_beat      = hv && beat_pending_q && !done;
    res_d.req_final     = hv && beat_pending_q && beat_at_end;
    res_d.push_dropped  = (s1_mode_q == MODE_PUSH) && full;
    res_d.hit           = look_hit;
    res_d.hit_index     = look_hit ? HIT_IDX_W'(match.idx) : '0;
    res_d.hit_word_ok   = look_hit && offs_ok;
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = s2_valid_q;
  assign ready_res_o     = res_q.ready_res;
  assign high_priority_o = res_q.high_priority;
  assign req_valid_o     = res_q.req_valid;
  assign req_addr_o      = res_q.req_addr;
  assign req_data_o      = res_q.req_valid ? head_word : '0;
  assign req_beat_o      = res_q.req_beat;
  assign req_final_o     = res_q.req_final;
  assign push_dropped_o  = res_q.push_dropped;
  assign hit_o           = res_q.hit;
  assign hit_index_o     = res_q.hit_index;
  assign hit_word_o      = res_q.hit_word_ok ? look_word : '0;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`include "cache_line_write_buffer_unit_assert.svh"

  `CWB_ASSERT(a_occ_tracks_valid, $countones(entry_valid_q) == int'(occ_q), "occupancy out of step with valid bits")
  `CWB_ASSERT(a_idle_head_no_beat, !entry_valid_q[head_ptr_q] |-> (!beat_pending_q && beat_index_q == '0), "burst state live with invalid head")
  `CWB_ASSERT_NEXT(a_commit_sets_valid, s1_fire && push_ok && s1_push_last_q, entry_valid_q[$past(tail_ptr_q)], "committed line not marked valid")

endmodule

/* hw/rtl/cwb_word_ram.sv */
// ----------------------------------------------------------------------------
// Cache line write buffer - word store
// One write port, two registered read ports, read returns the old word.
// ----------------------------------------------------------------------------
module cwb_word_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

/* hw/rtl/cwb_lookup.sv */
// ----------------------------------------------------------------------------
// Cache line write buffer - lookup match
// Compares all entry addresses, picks the lowest valid matching index.
// ----------------------------------------------------------------------------
module cwb_lookup import cwb_pkg::*; (
  input  logic [ENTRIES-1:0] entry_valid_i,
  input  logic [ADDR_W-1:0]  entry_addr_i [ENTRIES],
  input  logic [ADDR_W-1:0]  line_addr_i,
  output cwb_match_t         match_o
);

  logic [ENTRIES-1:0] eq;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      eq[i] = entry_valid_i[i] && (entry_addr_i[i] == line_addr_i);
    end
  end

  // Walk downward so the lowest index wins
  always_comb begin
    match_o = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (eq[i]) begin
        match_o.hit = 1'b1;
        match_o.idx = PTR_W'(i);
      end
    end
  end

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// Cache line write buffer unit - testbench
// Drives push, drain, lookup and idle beats with random gaps on both
// channels. A cycle-level predictor of the buffer runs in step with every
// accepted beat, and each output beat is compared field by field.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cwb_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;  // several times the slowest clean run
  localparam int RANDOM_BEATS = 1200;
  localparam int PHASE_BEATS  = 150;
  localparam int MAX_WAIT     = 18;

  // One input beat, field for field as on the ports
  typedef struct packed {
    cwb_mode_e            mode;
    logic                 arb_done;
    logic                 arb_last;
    logic [ADDR_W-1:0]    line_addr;
    logic [OFFS_W-1:0]    word_offset;
    logic [WORD_W-1:0]    push_word;
    logic                 push_last;
  } beat_t;

  // Everything the buffer reports for one beat
  typedef struct packed {
    logic                 ready_res;
    logic                 high_priority;
    logic                 req_valid;
    logic [ADDR_W-1:0]    req_addr;
    logic [WORD_W-1:0]    req_data;
    logic                 req_beat;
    logic                 req_final;
    logic                 push_dropped;
    logic                 hit;
    logic [HIT_IDX_W-1:0] hit_index;
    logic [WORD_W-1:0]    hit_word;
  } wbuf_view_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_HIGH_WM;
  logic [WM_W-1:0]      cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           mode_i = MODE_IDLE;
  logic                 arb_done_i = 1'b0;
  logic                 arb_last_i = 1'b0;
  logic [ADDR_W-1:0]    line_addr_i = '0;
  logic [OFFS_W-1:0]    word_offset_i = '0;
  logic [WORD_W-1:0]    push_word_i = '0;
  logic                 push_last_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 ready_res_o;
  logic                 high_priority_o;
  logic                 req_valid_o;
  logic [ADDR_W-1:0]    req_addr_o;
  logic [WORD_W-1:0]    req_data_o;
  logic                 req_beat_o;
  logic                 req_final_o;
  logic                 push_dropped_o;
  logic                 hit_o;
  logic [HIT_IDX_W-1:0] hit_index_o;
  logic [WORD_W-1:0]    hit_word_o;

  cache_line_write_buffer_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .arb_done_i      (arb_done_i),
    .arb_last_i      (arb_last_i),
    .line_addr_i     (line_addr_i),
    .word_offset_i   (word_offset_i),
    .push_word_i     (push_word_i),
    .push_last_i     (push_last_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .ready_res_o     (ready_res_o),
    .high_priority_o (high_priority_o),
    .req_valid_o     (req_valid_o),
    .req_addr_o      (req_addr_o),
    .req_data_o      (req_data_o),
    .req_beat_o      (req_beat_o),
    .req_final_o     (req_final_o),
    .push_dropped_o  (push_dropped_o),
    .hit_o           (hit_o),
    .hit_index_o     (hit_index_o),
    .hit_word_o      (hit_word_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the buffer and its watermarks
  // --------------------------------------------------------------------------
  logic                 slot_valid [ENTRIES];
  logic [ADDR_W-1:0]    slot_addr  [ENTRIES];
  logic [WORD_W-1:0]    slot_words [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] word_seen;     // word written at least once since reset
  int                   head_slot;
  int                   tail_slot;
  int                   fill_level;
  int                   beat_idx;
  logic                 beat_armed;
  logic                 prio_raised;
  int                   high_wm;
  int                   low_wm;

  wbuf_view_t           wbuf_view_q[$];  // predicted outputs, oldest first

  // Run statistics
  int beats_sent;
  int views_checked;
  int mismatches;
  int lines_committed;
  int lines_drained;
  int pushes_dropped;
  int lookup_hits;
  int prio_beats;
  int wm_settings;
  int cycles;

  // Stall control: quiet means no gaps on that side
  bit src_quiet;
  bit sink_quiet;

  logic [ADDR_W-1:0] addr_pool [6];

  task automatic clear_buffer_model();
    for (int i = 0; i < ENTRIES; i++) begin
      slot_valid[i] = 1'b0;
      slot_addr[i]  = '0;
    end
    for (int i = 0; i < MEM_DEPTH; i++) slot_words[i] = '0;
    word_seen   = '0;
    head_slot   = 0;
    tail_slot   = 0;
    fill_level  = 0;
    beat_idx    = 0;
    beat_armed  = 1'b0;
    prio_raised = 1'b0;
    high_wm     = int'(HIGH_WM_RST);
    low_wm      = int'(LOW_WM_RST);
  endtask

  // One beat of the buffer: outputs from the state at the start of the
  // beat, then the drain side and the push side update.
  task automatic buffer_cycle(input beat_t b, output wbuf_view_t o);
    logic done;
    logic last;
    logic head_v;
    logic full;
    logic found;
    int   bi;
    int   t;
    done   = (b.mode == MODE_DRAIN) && b.arb_done;
    last   = (b.mode == MODE_DRAIN) && b.arb_last;
    head_v = slot_valid[head_slot];
    full   = fill_level >= ENTRIES;
    bi     = (beat_idx < LINE_WORDS) ? beat_idx : LINE_WORDS - 1;
    found  = 1'b0;

    // hysteresis: raise test wins when the watermarks cross
    if (fill_level >= high_wm) prio_raised = 1'b1;
    else if (fill_level <= low_wm) prio_raised = 1'b0;

    o = '0;
    o.ready_res     = !full;
    o.high_priority = prio_raised;
    o.req_valid     = head_v;
    if (head_v) begin
      o.req_addr  = slot_addr[head_slot];
      o.req_data  = slot_words[head_slot * LINE_WORDS + bi];
      o.req_beat  = beat_armed && !done;
      o.req_final = beat_armed && (bi == LINE_WORDS - 1);
    end
    o.push_dropped = (b.mode == MODE_PUSH) && full;

    // lowest index wins among matching lines
    if (b.mode == MODE_LOOKUP) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (!found && slot_valid[i] && slot_addr[i] == b.line_addr) begin
          found       = 1'b1;
          o.hit       = 1'b1;
          o.hit_index = HIT_IDX_W'(i);
          if (int'(b.word_offset) < LINE_WORDS)
            o.hit_word = slot_words[i * LINE_WORDS + int'(b.word_offset)];
        end
      end
    end

    if (head_v) begin
      beat_armed = (bi == 0) ? 1'b1 : !done;
      if (done && bi < LINE_WORDS - 1) bi++;
      beat_idx = bi;
      if (last) begin
        slot_valid[head_slot] = 1'b0;
        beat_armed = 1'b0;
        beat_idx   = 0;
        if (fill_level > 0) begin
          head_slot = (head_slot + 1) % ENTRIES;
          fill_level--;
        end
        lines_drained++;
      end
    end

    if (b.mode == MODE_PUSH && !full) begin
      t = tail_slot;
      slot_addr[t] = b.line_addr;
      if (int'(b.word_offset) < LINE_WORDS) begin
        slot_words[t * LINE_WORDS + int'(b.word_offset)] = b.push_word;
        word_seen[t * LINE_WORDS + int'(b.word_offset)]  = 1'b1;
      end
      if (b.push_last) begin
        slot_valid[t] = 1'b1;
        tail_slot = (t + 1) % ENTRIES;
        fill_level++;
        lines_committed++;
      end
    end

    if (o.push_dropped) pushes_dropped++;
    if (o.hit) lookup_hits++;
    if (o.high_priority) prio_beats++;
  endtask

  // A line may only become valid once every one of its words has been
  // written, so no burst or lookup ever reads a word nobody stored.
  function automatic logic commit_is_safe(beat_t b);
    logic [LINE_WORDS-1:0] mask;
    mask = word_seen[tail_slot * LINE_WORDS +: LINE_WORDS];
    if (int'(b.word_offset) < LINE_WORDS) mask[b.word_offset] = 1'b1;
    return &mask;
  endfunction

  // --------------------------------------------------------------------------
  // Beat builders
  // --------------------------------------------------------------------------
  function automatic int draw_wait(bit quiet);
    if (quiet || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, MAX_WAIT);
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    if ($urandom_range(0, 9) < 7) return addr_pool[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  // Everything random, arbiter flags included in every mode
  function automatic beat_t noise_beat();
    beat_t b;
    b.mode        = cwb_mode_e'($urandom_range(0, 3));
    b.arb_done    = 1'($urandom_range(0, 1));
    b.arb_last    = 1'($urandom_range(0, 1));
    b.line_addr   = $urandom;
    b.word_offset = OFFS_W'($urandom_range(0, 15));
    b.push_word   = $urandom;
    b.push_last   = 1'($urandom_range(0, 1));
    return b;
  endfunction

  function automatic beat_t push_beat(logic [ADDR_W-1:0] addr, int offs,
                                      logic [WORD_W-1:0] word, logic last);
    beat_t b;
    b             = noise_beat();
    b.mode        = MODE_PUSH;
    b.line_addr   = addr;
    b.word_offset = OFFS_W'(offs);
    b.push_word   = word;
    b.push_last   = last;
    return b;
  endfunction

  function automatic beat_t drain_beat(logic done, logic last);
    beat_t b;
    b          = noise_beat();
    b.mode     = MODE_DRAIN;
    b.arb_done = done;
    b.arb_last = last;
    return b;
  endfunction

  function automatic beat_t lookup_beat(logic [ADDR_W-1:0] addr, int offs);
    beat_t b;
    b             = noise_beat();
    b.mode        = MODE_LOOKUP;
    b.line_addr   = addr;
    b.word_offset = OFFS_W'(offs);
    return b;
  endfunction

  function automatic beat_t idle_beat();
    beat_t b;
    b      = noise_beat();
    b.mode = MODE_IDLE;
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers
  // --------------------------------------------------------------------------

  // Valid stays high across back-to-back beats; it only drops for a gap.
  task automatic send_beat(input beat_t b);
    int         gap;
    wbuf_view_t exp;
    if (b.mode == MODE_PUSH && b.push_last && fill_level < ENTRIES && !commit_is_safe(b))
      b.push_last = 1'b0;
    gap = draw_wait(src_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= b.mode;
    arb_done_i    <= b.arb_done;
    arb_last_i    <= b.arb_last;
    line_addr_i   <= b.line_addr;
    word_offset_i <= b.word_offset;
    push_word_i   <= b.push_word;
    push_last_i   <= b.push_last;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    buffer_cycle(b, exp);
    wbuf_view_q.push_back(exp);
    beats_sent++;
  endtask

  // Hold off the input until every predicted beat has come back
  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    while (wbuf_view_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Both watermark registers, back to back on the config channel
  task automatic set_watermarks(input int hi, input int lo);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_HIGH_WM;
    cfg_data_i  <= WM_W'(hi);
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    high_wm = hi;
    cfg_index_i <= CFG_LOW_WM;
    cfg_data_i  <= WM_W'(lo);
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    low_wm = lo;
    cfg_valid_i <= 1'b0;
    wm_settings++;
  endtask

  // Result side: random stall before taking each beat
  initial begin : result_sink
    int stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_wait(sink_quiet);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  // --------------------------------------------------------------------------
  // Output checking
  // --------------------------------------------------------------------------
  function automatic void compare_field(string name, logic [31:0] exp, logic [31:0] got);
    if (exp !== got) begin
      $error("%s mismatch: expected %h, got %h", name, exp, got);
      mismatches++;
    end
  endfunction

  task automatic check_view(input wbuf_view_t exp);
    compare_field("ready_res",     32'(exp.ready_res),     32'(ready_res_o));
    compare_field("high_priority", 32'(exp.high_priority), 32'(high_priority_o));
    compare_field("req_valid",     32'(exp.req_valid),     32'(req_valid_o));
    compare_field("req_addr",      exp.req_addr,           req_addr_o);
    compare_field("req_data",      exp.req_data,           req_data_o);
    compare_field("req_beat",      32'(exp.req_beat),      32'(req_beat_o));
    compare_field("req_final",     32'(exp.req_final),     32'(req_final_o));
    compare_field("push_dropped",  32'(exp.push_dropped),  32'(push_dropped_o));
    compare_field("hit",           32'(exp.hit),           32'(hit_o));
    compare_field("hit_index",     32'(exp.hit_index),     32'(hit_index_o));
    compare_field("hit_word",      exp.hit_word,           hit_word_o);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (wbuf_view_q.size() == 0) begin
        $error("output beat with nothing predicted");
        mismatches++;
      end else begin
        check_view(wbuf_view_q.pop_front());
        views_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still predicted",
               cycles, wbuf_view_q.size());
      $display("testbench: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Traffic sequences
  // --------------------------------------------------------------------------

  // One line, word by word, committed on its final word. Offsets are
  // sometimes shuffled, drains and lookups sneak in, and now and then the
  // line is committed early. On a full buffer only stray pushes are sent.
  task automatic push_line_seq();
    int                order [LINE_WORDS];
    int                j;
    int                tmp;
    logic [ADDR_W-1:0] a;
    if (fill_level >= ENTRIES) begin
      repeat ($urandom_range(1, 2))
        send_beat(push_beat(pick_addr(), $urandom_range(0, 15), pick_word(),
                            1'($urandom_range(0, 1))));
      return;
    end
    a = pick_addr();
    for (int k = 0; k < LINE_WORDS; k++) order[k] = k;
    if ($urandom_range(0, 9) < 3) begin
      for (int k = LINE_WORDS - 1; k > 0; k--) begin
        j        = $urandom_range(0, k);
        tmp      = order[k];
        order[k] = order[j];
        order[j] = tmp;
      end
    end
    for (int k = 0; k < LINE_WORDS; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1)) send_beat(lookup_beat(a, $urandom_range(0, 15)));
        else send_beat(drain_beat(1'($urandom_range(0, 1)), 1'b0));
      end
      if (k < LINE_WORDS - 1 && $urandom_range(0, 39) == 0) begin
        send_beat(push_beat(a, order[k], pick_word(), 1'b1));
        return;
      end
      send_beat(push_beat(a, order[k], pick_word(), k == LINE_WORDS - 1));
    end
  endtask

  // Write burst of the head line: done beats with arbiter stalls, idle and
  // lookup cycles mixed in, sometimes cut short or run past the line end; with no head line, stray drain beats only.
  task automatic drain_burst_seq();
    int taken;
    int target;
    if (!slot_valid[head_slot]) begin
      repeat ($urandom_range(1, 2))
        send_beat(drain_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
      return;
    end
    target = LINE_WORDS;
    if ($urandom_range(0, 9) == 0) target = $urandom_range(0, LINE_WORDS - 1);
    else if ($urandom_range(0, 9) == 0) target = LINE_WORDS + $urandom_range(1, 4);
    taken = 0;
    while (taken < target) begin
      case ($urandom_range(0, 9))
        0:       send_beat(drain_beat(1'b0, 1'b0));
        1:       send_beat(idle_beat());
        2:       send_beat(lookup_beat(pick_addr(), $urandom_range(0, 15)));
        default: begin
          send_beat(drain_beat(1'b1, 1'b0));
          taken++;
        end
      endcase
    end
    send_beat(drain_beat(1'b1, 1'b1));
  endtask

  // Lookups, some aimed at lines that are actually held
  task automatic lookup_seq();
    int                idx;
    logic [ADDR_W-1:0] a;
    repeat ($urandom_range(1, 3)) begin
      idx = $urandom_range(0, ENTRIES - 1);
      a   = (slot_valid[idx] && $urandom_range(0, 1)) ? slot_addr[idx] : pick_addr();
      send_beat(lookup_beat(a, $urandom_range(0, 15)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty buffer at reset watermarks: arbiter last with no head line,
  // idle mode, lookups that must miss.
  task automatic test_empty_buffer();
    send_beat(drain_beat(1'b1, 1'b1));
    send_beat(drain_beat(1'b0, 1'b0));
    send_beat(idle_beat());
    send_beat(lookup_beat('1, 15));
    send_beat(lookup_beat('0, 0));
  endtask

  // Fill all slots with full lines (so every stored word is known), then
  // push into the full buffer and look up duplicate and missing addresses.
  task automatic test_fill_and_overflow();
    logic [ADDR_W-1:0] la [ENTRIES];
    logic [WORD_W-1:0] w;
    for (int n = 0; n < ENTRIES; n++) la[n] = $urandom;
    la[0] = '0;
    la[1] = '1;
    la[5] = la[2];  // duplicate: lookup must return the lower slot
    for (int n = 0; n < ENTRIES; n++) begin
      for (int k = 0; k < LINE_WORDS; k++) begin
        if (n == 0) w = k[0] ? '1 : '0;
        else if (n == 1) w = '1;
        else w = $urandom;
        send_beat(push_beat(la[n], k, w, k == LINE_WORDS - 1));
        // uncommitted line is not visible yet
        if (n == 0 && k == 8) send_beat(lookup_beat(la[0], 0));
      end
    end
    send_beat(push_beat($urandom, 3, $urandom, 1'b0));
    send_beat(push_beat($urandom, 15, $urandom, 1'b1));
    send_beat(lookup_beat(la[5], 15));
    send_beat(lookup_beat(la[1], 0));
    send_beat(lookup_beat(la[7], 7));
    send_beat(lookup_beat($urandom, 9));
  endtask

  // Bursts from the full buffer: stalls, beats past the line end,
  // early last, last on the very first cycle, then last with no line.
  task automatic test_drain_burst();
    send_beat(drain_beat(1'b0, 1'b0));
    send_beat(drain_beat(1'b0, 1'b0));
    for (int k = 0; k < LINE_WORDS + 3; k++) begin
      if (k == 4) send_beat(idle_beat());
      if (k == 9) send_beat(push_beat($urandom, k, $urandom, 1'b0));
      send_beat(drain_beat(1'b1, 1'b0));
    end
    send_beat(drain_beat(1'b1, 1'b1));
    repeat (5) send_beat(drain_beat(1'b1, 1'b0));
    send_beat(drain_beat(1'b0, 1'b1));
    send_beat(drain_beat(1'b0, 1'b1));
    while (slot_valid[head_slot]) drain_burst_seq();
    send_beat(drain_beat(1'b1, 1'b1));
  endtask

  // Phases of mixed traffic, each under its own watermark pair: the
  // extremes and crossed pairs first, then random ones. Even phases lean
  // toward filling, odd ones toward draining.
  task automatic test_random_traffic();
    int start;
    int stop;
    int phase;
    int hi;
    int lo;
    int pick;
    int push_share;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < 6; i++) addr_pool[i] = $urandom;
    start = beats_sent;
    phase = 0;
    while (beats_sent - start < RANDOM_BEATS) begin
      pause_until_drained();
      case (phase)
        0:       begin hi = 0; lo = 8; end
        1:       begin hi = 8; lo = 0; end
        2:       begin hi = 8; lo = 8; end
        3:       begin hi = 0; lo = 0; end
        4:       begin hi = 4; lo = 4; end
        5:       begin hi = 3; lo = 5; end
        default: begin
          hi = $urandom_range(0, 8);
          lo = $urandom_range(0, 8);
        end
      endcase
      set_watermarks(hi, lo);
      src_quiet  = (phase % 3 == 1);
      sink_quiet = (phase % 4 == 2);
      push_share = (phase % 2 == 0) ? 45 : 25;
      stop = beats_sent + PHASE_BEATS;
      while (beats_sent < stop) begin
        pick = $urandom_range(0, 99);
        if (pick < push_share) push_line_seq();
        else if (pick < 70) drain_burst_seq();
        else if (pick < 85) lookup_seq();
        else if (pick < 98) repeat ($urandom_range(1, 4)) send_beat(noise_beat());
        else pause_until_drained();
      end
      phase++;
    end
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    clear_buffer_model();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_buffer();
    test_fill_and_overflow();
    test_drain_burst();
    test_random_traffic();

    // let the last beats come back, then wait quietly for strays
    in_valid_i <= 1'b0;
    while (wbuf_view_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("run: %0d beats sent, %0d output beats checked, %0d watermark pairs",
             beats_sent, views_checked, wm_settings);
    $display("run: %0d lines committed, %0d drained, %0d pushes dropped, %0d hits, %0d high",
             lines_committed, lines_drained, pushes_dropped, lookup_hits, prio_beats);
    if (mismatches == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
